// ----- rtl/vdd_pkg.sv -----
// ----------------------------------------------------------------------------
// vdd_pkg
// Shared constants, payload types and control structs for the vertex
// descriptor deduplication block.
// ----------------------------------------------------------------------------
package vdd_pkg;

	localparam int unsigned REGISTRY_DEPTH = 1024;
	localparam int unsigned REF_WIDTH      = 20;
	localparam int unsigned FIELD_W        = 20;
	localparam int unsigned INDEX_W        = 10;
	localparam int unsigned KEY_W          = 3 * REF_WIDTH;
	localparam int unsigned ADDR_W         = $clog2(REGISTRY_DEPTH);
	localparam int unsigned CNT_W          = $clog2(REGISTRY_DEPTH + 1);

	typedef logic [REF_WIDTH-1:0] ref_t;
	typedef logic [KEY_W-1:0]     key_t;

	typedef struct packed {
		logic               new_mesh;
		logic [FIELD_W-1:0] position_ref;
		logic [FIELD_W-1:0] texcoord_ref;
		logic [FIELD_W-1:0] normal_ref;
	} desc_t;

	typedef struct packed {
		logic [INDEX_W-1:0] element_index;
		logic               is_new;
		logic               overflow;
		logic [FIELD_W-1:0] position_out;
		logic [FIELD_W-1:0] texcoord_out;
		logic [FIELD_W-1:0] normal_out;
	} elem_t;

	// controller -> datapath
	typedef struct packed {
		logic start;
		logic scan;
		logic finish;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic hit;
		logic scan_done;
		logic slot_free;
	} ctrl_status_t;

	// 1-based to 0-based, wraps within REF_WIDTH bits
	function automatic ref_t to_zero_based(logic [FIELD_W-1:0] ref_in);
		ref_t r;
		r = REF_WIDTH'(ref_in);
		return r - REF_WIDTH'(1);
	endfunction

endpackage

// ----- rtl/vdd_stream_if.sv -----
// ----------------------------------------------------------------------------
// vdd_desc_if / vdd_elem_if
// Valid/ready channels for descriptors in and index elements out.
// ----------------------------------------------------------------------------
interface vdd_desc_if;
	logic           valid;
	logic           ready;
	vdd_pkg::desc_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface vdd_elem_if;
	logic           valid;
	logic           ready;
	vdd_pkg::elem_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/vdd_ctrl.sv -----
// ----------------------------------------------------------------------------
// vdd_ctrl
// Sequencer: accept a descriptor, run the registry scan, then retire the
// result into the output register.
// ----------------------------------------------------------------------------
module vdd_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  vdd_pkg::ctrl_status_t st,
	output vdd_pkg::ctrl_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (st.hit || st.scan_done) state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (st.slot_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign cmd.start  = (state_q == ST_IDLE) && in_valid;
	assign cmd.scan   = (state_q == ST_SCAN);
	assign cmd.finish = (state_q == ST_FINISH) && st.slot_free;

endmodule

// ----- rtl/vdd_datapath.sv -----
// ----------------------------------------------------------------------------
// vdd_datapath
// Registry memory, scan address counter, compare stage, entry count and
// the output register.
// ----------------------------------------------------------------------------
module vdd_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  vdd_pkg::desc_t        in_payload,
	input  vdd_pkg::ctrl_cmd_t    cmd,
	output vdd_pkg::ctrl_status_t st,
	output logic                  out_valid,
	input  logic                  out_ready,
	output vdd_pkg::elem_t        out_payload
);

	localparam int unsigned RW = vdd_pkg::REF_WIDTH;

	vdd_pkg::key_t                mem [vdd_pkg::REGISTRY_DEPTH];
	vdd_pkg::key_t                key_q;
	vdd_pkg::key_t                rd_data_s1;
	logic [vdd_pkg::CNT_W-1:0]    count_q;
	logic [vdd_pkg::CNT_W-1:0]    scan_idx_q;
	logic [vdd_pkg::ADDR_W-1:0]   cmp_idx_s1;
	logic                         cmp_vld_s1;
	logic                         found_q;
	logic [vdd_pkg::ADDR_W-1:0]   hit_idx_q;
	logic                         out_valid_q;
	vdd_pkg::elem_t               out_q;

	logic issue;
	logic match;
	logic full;
	logic store_new;

	assign issue     = cmd.scan && (scan_idx_q < count_q);
	assign match     = cmd.scan && cmp_vld_s1 && (rd_data_s1 == key_q);
	assign full      = (count_q == vdd_pkg::CNT_W'(vdd_pkg::REGISTRY_DEPTH));
	assign store_new = cmd.finish && !found_q && !full;

	assign st.hit       = match;
	assign st.scan_done = cmd.scan && !issue && !cmp_vld_s1;
	assign st.slot_free = !out_valid_q || out_ready;

	// single-port registry: append or scan read, never both
	always_ff @(posedge clk) begin
		if (store_new) mem[count_q[vdd_pkg::ADDR_W-1:0]] <= key_q;
		if (issue) rd_data_s1 <= mem[scan_idx_q[vdd_pkg::ADDR_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q <= {vdd_pkg::to_zero_based(in_payload.normal_ref),
			          vdd_pkg::to_zero_based(in_payload.texcoord_ref),
			          vdd_pkg::to_zero_based(in_payload.position_ref)};
		end
		if (issue) cmp_idx_s1 <= scan_idx_q[vdd_pkg::ADDR_W-1:0];
		if (match) hit_idx_q <= cmp_idx_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			scan_idx_q <= '0;
			cmp_vld_s1 <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			cmp_vld_s1 <= issue;
			if (cmd.start) begin
				scan_idx_q <= '0;
				found_q    <= 1'b0;
				if (in_payload.new_mesh) count_q <= '0;
			end else begin
				if (issue) scan_idx_q <= scan_idx_q + vdd_pkg::CNT_W'(1);
				if (match) found_q <= 1'b1;
				if (store_new) count_q <= count_q + vdd_pkg::CNT_W'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q <= '0;
			if (found_q) begin
				out_q.element_index <= vdd_pkg::INDEX_W'(hit_idx_q);
			end else if (full) begin
				out_q.overflow <= 1'b1;
			end else begin
				out_q.element_index <= vdd_pkg::INDEX_W'(count_q);
				out_q.is_new        <= 1'b1;
				out_q.position_out  <= vdd_pkg::FIELD_W'(key_q[RW-1:0]);
				out_q.texcoord_out  <= vdd_pkg::FIELD_W'(key_q[2*RW-1:RW]);
				out_q.normal_out    <= vdd_pkg::FIELD_W'(key_q[3*RW-1:2*RW]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_payload = out_q;

endmodule

// ----- rtl/vertex_descriptor_dedup.sv -----
// ----------------------------------------------------------------------------
// vertex_descriptor_dedup
// Merges identical face-corner descriptors into an index buffer registry.
// ----------------------------------------------------------------------------
// Timing: on a miss the result is valid after a scan of all N registry entries,
//   N = entries in the registry (0 to 1024); a hit at entry i ends the scan
//   there. A busy output slot stalls the retire.
// Flow: one descriptor at a time, through the sequential scan of the
//   single-port registry memory (one entry/cycle), then back in IDLE to
//   take the next transfer.
// Reset: registry count cleared, so the registry is empty; stored triples are
//   left as they are and are never read before being rewritten.
// ----------------------------------------------------------------------------
module vertex_descriptor_dedup (
	input  logic        clk,
	input  logic        arst_n,
	vdd_desc_if.sink    desc,
	vdd_elem_if.source  elem
);

	// controller <-> datapath handshake
	vdd_pkg::ctrl_cmd_t    cmd;
	vdd_pkg::ctrl_status_t st;

	// Sequencer: IDLE takes a transfer, SCAN walks the registry until a hit
	// or the last valid entry has been compared, FINISH waits for the output
	// register to be free and loads the result (appending on a miss unless full).
	vdd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (desc.valid),
		.in_ready (desc.ready),
		.st       (st),
		.cmd      (cmd)
	);

	// Datapath: registry memory with registered read, one-deep compare stage,
	// entry count and the result register feeding the output channel. The
	// next descriptor may be taken while a result still waits in the output.
	vdd_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_payload  (desc.payload),
		.cmd         (cmd),
		.st          (st),
		.out_valid   (elem.valid),
		.out_ready   (elem.ready),
		.out_payload (elem.payload)
	);

`ifndef SYNTHESIS
	// a result is never both appended and overflowed
	assert property (@(posedge clk) disable iff (!arst_n)
		elem.valid |-> !(elem.payload.is_new && elem.payload.overflow))
		else $error("is_new and overflow set together");

	// the sequencer only retires into a free output slot
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!elem.valid || elem.ready))
		else $error("result retired over a pending transfer");

	// a fresh result appears only after a retire command
	assert property (@(posedge clk) disable iff (!arst_n)
		(elem.valid && !$past(elem.valid)) |-> $past(cmd.finish))
		else $error("output valid without retire");
`endif

endmodule
